>>> hw/rtl/a85_pkg.sv
`default_nettype none
package a85_pkg;

    localparam logic [0:0]  OP_DATA    = 1'b0;
    localparam logic [0:0]  OP_FLUSH   = 1'b1;

    localparam logic [31:0] DIV85_MAGIC = 32'hC0C0C0C1;
    localparam int unsigned DIV85_SHIFT = 38;
    localparam int unsigned QUOT_W      = 64 - DIV85_SHIFT;
    localparam logic [31:0] BASE        = 32'd85;

    localparam logic [7:0]  CHAR_OFFSET = 8'd33;
    localparam logic [7:0]  CHAR_ZERO   = 8'd122;
    localparam logic [7:0]  CHAR_NL     = 8'd10;
    localparam logic [7:0]  MIN_LINE    = 8'd5;
    localparam logic [7:0]  RESET_LINE  = 8'd72;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nchar;
        logic        zero;
        logic        flush;
    } t_job;

    typedef struct packed {
        logic [4:0][7:0] chars;
        logic [2:0]      nchar;
        logic            flush;
    } t_res;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out;

endpackage
`default_nettype wire

>>> hw/rtl/a85_fifo.sv
`default_nettype none
module a85_fifo #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned ADDR_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    localparam int unsigned DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [ADDR_W-1:0] r_wr;
    logic [ADDR_W-1:0] r_rd;
    logic [ADDR_W:0]   r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == (ADDR_W + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/a85_front.sv
`default_nettype none
module a85_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_op,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_job_push,
    output a85_pkg::t_job    o_job
);

    logic [7:0] r_b [3];
    logic [1:0] r_cnt;
    logic [31:0] data_word;
    logic [31:0] flush_word;

    assign data_word  = {r_b[0], r_b[1], r_b[2], i_data_byte};
    assign flush_word = {r_b[0],
                         (r_cnt >= 2'd2) ? r_b[1] : 8'h00,
                         (r_cnt == 2'd3) ? r_b[2] : 8'h00,
                         8'h00};

    always_comb begin
        o_job_push = 1'b0;
        o_job      = '0;
        if (i_op == a85_pkg::OP_FLUSH) begin
            o_job_push  = i_accept;
            o_job.word  = flush_word;
            o_job.nchar = (r_cnt == 2'd0) ? 3'd0 : ({1'b0, r_cnt} + 3'd1);
            o_job.flush = 1'b1;
        end else begin
            o_job_push  = i_accept && (r_cnt == 2'd3);
            o_job.word  = data_word;
            o_job.zero  = (data_word == 32'd0);
            o_job.nchar = (data_word == 32'd0) ? 3'd1 : 3'd5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_accept) begin
            if (i_op == a85_pkg::OP_FLUSH) begin
                r_cnt <= '0;
            end else if (r_cnt == 2'd3) begin
                r_cnt <= '0;
            end else begin
                r_b[r_cnt] <= i_data_byte;
                r_cnt      <= r_cnt + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/a85_conv.sv
`default_nettype none
module a85_conv (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire a85_pkg::t_job  i_job,
    output logic                o_job_pop,
    output logic                o_res_valid,
    output a85_pkg::t_res       o_res,
    input  wire logic           i_res_take
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [31:0]                   r_div;
    logic [63:0]                   r_prod;
    logic [6:0]                    r_dig [4];
    logic [1:0]                    r_step;
    logic                          r_zero;
    logic                          r_flush;
    logic [2:0]                    r_n;
    logic                          r_res_valid;
    a85_pkg::t_res                 r_res;

    logic [a85_pkg::QUOT_W-1:0]    quot;
    logic [31:0]                   mul_a;
    logic [63:0]                   mul_p;
    logic [31:0]                   rem;
    logic                          res_free;

    assign quot     = r_prod[63:a85_pkg::DIV85_SHIFT];
    assign mul_a    = (r_state == S_IDLE) ? i_job.word : 32'(quot);
    assign mul_p    = {32'd0, mul_a} * {32'd0, a85_pkg::DIV85_MAGIC};
    assign rem      = r_div - (32'(quot) * a85_pkg::BASE);
    assign res_free = !r_res_valid || i_res_take;

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (i_res_take) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_div   <= i_job.word;
                        r_prod  <= mul_p;
                        r_zero  <= i_job.zero;
                        r_flush <= i_job.flush;
                        r_n     <= i_job.nchar;
                        r_step  <= '0;
                        r_state <= (i_job.zero || i_job.nchar == 3'd0) ? S_DONE : S_CONV;
                    end
                end
                S_CONV: begin
                    r_dig[~r_step] <= rem[6:0];
                    r_div          <= 32'(quot);
                    r_prod         <= mul_p;
                    r_step         <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (res_free) begin
                        r_res.chars[0] <= r_zero ? a85_pkg::CHAR_ZERO
                                                 : ({1'b0, r_div[6:0]} + a85_pkg::CHAR_OFFSET);
                        for (int j = 1; j < 5; j++) begin
                            r_res.chars[j] <= {1'b0, r_dig[j-1]} + a85_pkg::CHAR_OFFSET;
                        end
                        r_res.nchar <= r_n;
                        r_res.flush <= r_flush;
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/a85_emit.sv
`default_nettype none
module a85_emit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_data,
    input  wire logic           i_res_valid,
    input  wire a85_pkg::t_res  i_res,
    output logic                o_res_take,
    input  wire logic           i_out_full,
    output logic                o_out_push,
    output a85_pkg::t_out       o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAR,
        S_WRAP,
        S_FINAL
    } t_state;

    t_state          r_state;
    logic [7:0]      r_line_len;
    logic [7:0]      r_col;
    logic [4:0][7:0] r_chars;
    logic [2:0]      r_n;
    logic            r_flush;
    logic [2:0]      r_k;

    logic [7:0]      eff_len;
    logic [7:0]      col_next;
    logic            wrap;
    logic            is_end;

    assign eff_len    = (r_line_len < a85_pkg::MIN_LINE) ? a85_pkg::MIN_LINE : r_line_len;
    assign col_next   = r_col + 8'd1;
    assign wrap       = (col_next >= eff_len);
    assign is_end     = (r_k == (r_n - 3'd1));
    assign o_res_take = (r_state == S_IDLE) && i_res_valid;

    always_comb begin
        o_out_push   = 1'b0;
        o_out        = '0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_CHAR: begin
                o_out_push   = !i_out_full;
                o_out.out_char = r_chars[r_k];
                o_out.last   = is_end && !wrap && !r_flush;
            end
            S_WRAP: begin
                o_out_push   = !i_out_full;
                o_out.out_char = a85_pkg::CHAR_NL;
                o_out.last   = is_end;
            end
            S_FINAL: begin
                o_out_push   = !i_out_full;
                o_out.out_char = a85_pkg::CHAR_NL;
                o_out.last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_line_len <= a85_pkg::RESET_LINE;
            r_col      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_line_len <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_res_valid) begin
                        r_chars <= i_res.chars;
                        r_n     <= i_res.nchar;
                        r_flush <= i_res.flush;
                        r_k     <= '0;
                        if (i_res.nchar != 3'd0) begin
                            r_state <= S_CHAR;
                        end else if (r_col != 8'd0) begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                S_CHAR: begin
                    if (!i_out_full) begin
                        if (wrap) begin
                            r_col   <= '0;
                            r_state <= S_WRAP;
                        end else begin
                            r_col <= col_next;
                            if (is_end) begin
                                r_state <= r_flush ? S_FINAL : S_IDLE;
                            end else begin
                                r_k <= r_k + 3'd1;
                            end
                        end
                    end
                end
                S_WRAP: begin
                    if (!i_out_full) begin
                        if (is_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= S_CHAR;
                        end
                    end
                end
                S_FINAL: begin
                    if (!i_out_full) begin
                        r_col   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/ascii85_line_encoder.sv
// A byte that completes a word goes straight into the job queue; the converter loads it,
// runs four divide steps (none for a zero word) and hands the result to the emitter.
// The converter (load, four divide steps, hand-off) and the emitter (a load step, then one
// character per cycle while the output queue is not full, plus a newline step per line end)
// work on different words at once, and new bytes are taken until the job queue fills.
// Reset: synchronous, active low; clears queues, pending tuple and column, line length 72.
`default_nettype none
module ascii85_line_encoder #(
    parameter int unsigned JOB_QUEUE_AW = 2,
    parameter int unsigned OUT_QUEUE_AW = 1
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic       i_op,
    input  wire logic [7:0] i_data_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_char,
    output logic            o_last,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic             accept;
    logic             job_push;
    a85_pkg::t_job    job_in;
    a85_pkg::t_job    job_out;
    logic             job_empty;
    logic             job_pop;
    logic             res_valid;
    a85_pkg::t_res    res;
    logic             res_take;
    logic             out_push;
    logic             out_full;
    a85_pkg::t_out    out_in;
    a85_pkg::t_out    out_head;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;
    assign o_out_char  = out_head.out_char;
    assign o_last      = out_head.last;

    a85_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    a85_fifo #(
        .DATA_W ($bits(a85_pkg::t_job)),
        .ADDR_W (JOB_QUEUE_AW)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    a85_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    a85_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_take  (res_take),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (out_in)
    );

    a85_fifo #(
        .DATA_W ($bits(a85_pkg::t_out)),
        .ADDR_W (OUT_QUEUE_AW)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty)
    );

endmodule
`default_nettype wire

>>> verif/tb_ascii85_line_encoder.sv
`default_nettype none
module tb_ascii85_line_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        op;
        logic [7:0]  b;
        int          n_typed;
        logic [47:0] typed;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic       i_op;
    logic [7:0] i_data_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_char;
    logic       o_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    logic [7:0] line_len;
    logic [7:0] tuple[4];
    logic [1:0] tuple_cnt;
    logic [7:0] col;

    a85_pkg::t_out chars_due[$];
    t_row          dir_tab[$];
    int            mismatches = 0;
    bit            quiet = 1'b0;
    bit            rst_done = 1'b0;

    ascii85_line_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_char  (o_out_char),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put_char(ref a85_pkg::t_out res[$], input logic [7:0] c);
        a85_pkg::t_out o;
        logic [7:0]    eff;
        eff = (line_len < a85_pkg::MIN_LINE) ? a85_pkg::MIN_LINE : line_len;
        o.out_char = c;
        o.last     = 1'b0;
        res.push_back(o);
        col = col + 8'd1;
        if (col >= eff) begin
            o.out_char = a85_pkg::CHAR_NL;
            res.push_back(o);
            col = 8'd0;
        end
    endfunction

    function automatic void word_digits(output logic [7:0] d[5]);
        logic [31:0] w;
        w = {tuple[0], tuple[1], tuple[2], tuple[3]};
        for (int i = 4; i >= 0; i--) begin
            d[i] = 8'(w % a85_pkg::BASE) + a85_pkg::CHAR_OFFSET;
            w    = w / a85_pkg::BASE;
        end
    endfunction

    function automatic void encode_a85(input logic op, input logic [7:0] b,
                                       ref a85_pkg::t_out res[$]);
        logic [7:0]    d[5];
        a85_pkg::t_out o;
        res.delete();
        if (op == a85_pkg::OP_DATA) begin
            tuple[tuple_cnt] = b;
            if (tuple_cnt < 2'd3) begin
                tuple_cnt = tuple_cnt + 2'd1;
            end else begin
                tuple_cnt = 2'd0;
                if ((tuple[0] | tuple[1] | tuple[2] | tuple[3]) == 8'd0) begin
                    put_char(res, a85_pkg::CHAR_ZERO);
                end else begin
                    word_digits(d);
                    for (int i = 0; i < 5; i++) put_char(res, d[i]);
                end
            end
        end else begin
            if (tuple_cnt != 2'd0) begin
                for (int i = int'(tuple_cnt); i < 4; i++) tuple[i] = 8'd0;
                word_digits(d);
                for (int i = 0; i <= int'(tuple_cnt); i++) put_char(res, d[i]);
                tuple_cnt = 2'd0;
            end
            if (col != 8'd0) begin
                o.out_char = a85_pkg::CHAR_NL;
                o.last     = 1'b0;
                res.push_back(o);
            end
            col = 8'd0;
        end
        if (res.size() > 0) begin
            o      = res[res.size() - 1];
            o.last = 1'b1;
            res[res.size() - 1] = o;
        end
    endfunction

    task automatic send_word(input logic op, input logic [7:0] b, input int n_typed,
                             input logic [47:0] typed);
        a85_pkg::t_out due[$];
        a85_pkg::t_out o;
        int            gap;
        gap = gap_len();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        encode_a85(op, b, due);
        if (n_typed >= 0) begin
            due.delete();
            for (int k = 0; k < n_typed; k++) begin
                o.out_char = typed[47 - 8 * k -: 8];
                o.last     = (k == n_typed - 1);
                due.push_back(o);
            end
        end
        foreach (due[k]) chars_due.push_back(due[k]);
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (chars_due.size() != 0);
    endtask

    task automatic write_line_len(input logic [7:0] v);
        hold_until_drained();
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        line_len = v;
    endtask

    // output side: random pop stalls, check every popped character
    initial begin
        a85_pkg::t_out want;
        int            rx_wait;
        rx_wait = 0;
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (chars_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got char %0d last %0b",
                             $time, o_out_char, o_last);
                    mismatches++;
                end else begin
                    want = chars_due.pop_front();
                    if (o_out_char !== want.out_char) begin
                        $display("%0t: out_char expected %0d got %0d",
                                 $time, want.out_char, o_out_char);
                        mismatches++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0b got %0b", $time, want.last, o_last);
                        mismatches++;
                    end
                end
            end
            if (!rst_done) begin
                pop <= 1'b0;
            end else if (rx_wait > 0) begin
                pop <= 1'b0;
                rx_wait--;
            end else begin
                pop <= 1'b1;
                rx_wait = gap_len();
            end
        end
    end

    initial begin
        logic [7:0] lens[7];
        logic [7:0] b;
        int         sent;
        int         r;

        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_op        <= a85_pkg::OP_DATA;
        i_data_byte <= 8'd0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'd0;

        line_len  = a85_pkg::RESET_LINE;
        tuple     = '{default: 8'd0};
        tuple_cnt = 2'd0;
        col       = 8'd0;

        // zero word, all-ones word, line end, empty flush, zero-byte flush, partial flushes
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h00, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h00, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h00, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h00, 1, {"z", 40'd0}});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 5, {"s8W-!", 8'd0}});
        dir_tab.push_back('{a85_pkg::OP_FLUSH, 8'hFF, 1, {a85_pkg::CHAR_NL, 40'd0}});
        dir_tab.push_back('{a85_pkg::OP_FLUSH, 8'h00, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h00, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_FLUSH, 8'h00, 3, {"!!", a85_pkg::CHAR_NL, 24'd0}});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'hFF, 0, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_FLUSH, 8'h5A, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h12, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h34, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h56, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h78, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h80, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_DATA,  8'h01, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_FLUSH, 8'h00, -1, 48'd0});
        dir_tab.push_back('{a85_pkg::OP_FLUSH, 8'h00, -1, 48'd0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;

        foreach (dir_tab[i])
            send_word(dir_tab[i].op, dir_tab[i].b, dir_tab[i].n_typed, dir_tab[i].typed);

        lens = '{8'd1, 8'd0, 8'd255, 8'd4, 8'd5, 8'd6, 8'($urandom_range(7, 254))};
        foreach (lens[p]) begin
            write_line_len(lens[p]);
            quiet = (p == 2);
            sent  = 0;
            while (sent < 40) begin
                if (p == 3 && sent >= 20 && sent < 24) begin
                    hold_until_drained();
                    sent = 24;
                end
                r = $urandom_range(0, 99);
                if (r < 9) begin
                    send_word(a85_pkg::OP_FLUSH, 8'($urandom_range(0, 255)), -1, 48'd0);
                    sent++;
                end else if (r < 17) begin
                    repeat (4) send_word(a85_pkg::OP_DATA, 8'd0, -1, 48'd0);
                    sent += 4;
                end else begin
                    r = $urandom_range(0, 9);
                    b = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
                    send_word(a85_pkg::OP_DATA, b, -1, 48'd0);
                    sent++;
                end
            end
        end
        quiet = 1'b0;

        hold_until_drained();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
